// ===== rtl/fcw_pkg.sv =====
// Shared types, constants and codes for the FAT cluster chain walker.
`default_nettype none

package fcw_pkg;

   // Table formats held in the fat_type register.
   localparam logic [1:0] FatType12 = 2'd0;
   localparam logic [1:0] FatType16 = 2'd1;
   localparam logic [1:0] FatType32 = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CsrFatType     = 2'd0;
   localparam logic [1:0] CsrFatStart    = 2'd1;
   localparam logic [1:0] CsrSectorBytes = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [1:0]  FatTypeReset     = FatType32;
   localparam logic [15:0] FatStartReset    = 16'd32;
   localparam logic [12:0] SectorBytesReset = 13'd512;

   // Upper bounds of a usable cluster number for each format.
   localparam logic [31:0] Limit12 = 32'h0000_0fef;
   localparam logic [31:0] Limit16 = 32'h0000_ffef;
   localparam logic [31:0] Limit32 = 32'h0fff_ffef;
   localparam logic [31:0] MinCluster = 32'h0000_0002;

   // Table read sizes in bytes.
   localparam logic [2:0] ReadBytesShort = 3'd2;
   localparam logic [2:0] ReadBytesLong  = 3'd4;

   // Result kinds.
   localparam logic [2:0] KindElement    = 3'd0;
   localparam logic [2:0] KindReadReq    = 3'd1;
   localparam logic [2:0] KindEndOfChain = 3'd2;
   localparam logic [2:0] KindBadStart   = 3'd3;
   localparam logic [2:0] KindUnexpected = 3'd4;

   // Input operations.
   localparam logic OpStart = 1'b0;
   localparam logic OpEntry = 1'b1;

   // Configuration as seen by the walk logic.
   typedef struct packed {
      logic [1:0]  fat_type;
      logic [28:0] base_address;
   } csr_type;

   // One result transaction.
   typedef struct packed {
      logic [2:0]  kind;
      logic [27:0] cluster;
      logic [30:0] read_address;
      logic [2:0]  read_bytes;
      logic        last;
   } result_type;

   // The one or two results caused by one input transaction.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } pair_type;

endpackage : fcw_pkg

`default_nettype wire

// ===== rtl/fcw_csr.sv =====
// Configuration registers and the precomputed table base address.
`default_nettype none

module fcw_csr (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [15:0]            csr_data,
   output      fcw_pkg::csr_type       csr_out
);
   import fcw_pkg::*;

   logic [1:0]  fat_type_ff;
   logic [15:0] fat_start_ff;
   logic [12:0] sector_bytes_ff;
   logic [28:0] base_ff;
   logic [28:0] base_in;

   assign csr_ready = 1'b1;

   // Register writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         fat_type_ff     <= FatTypeReset;
         fat_start_ff    <= FatStartReset;
         sector_bytes_ff <= SectorBytesReset;
      end else if (csr_valid) begin
         case (csr_index)
            CsrFatType:     fat_type_ff     <= csr_data[1:0];
            CsrFatStart:    fat_start_ff    <= csr_data;
            CsrSectorBytes: sector_bytes_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // The table base byte address, registered after the multiply.
   assign base_in = 29'(fat_start_ff * sector_bytes_ff);

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   assign csr_out.fat_type     = fat_type_ff;
   assign csr_out.base_address = base_ff;

endmodule : fcw_csr

`default_nettype wire

// ===== rtl/fcw_core.sv =====
// Input register, walk state and the combinational entry decode.
`default_nettype none

module fcw_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [63:0]            req_tdata,
   input  wire logic                   req_tuser,
   input  wire fcw_pkg::csr_type       csr_in,
   input  wire logic                   buf_space,
   output      logic                   pair_valid,
   output      fcw_pkg::pair_type      pair_out
);
   import fcw_pkg::*;

   logic        in_valid_ff;
   logic        in_op_ff;
   logic [31:0] in_start_ff;
   logic [31:0] in_entry_ff;
   logic [27:0] cur_ff;
   logic [27:0] cur_in;
   logic        walking_ff;
   logic        walking_in;
   logic        advance;
   logic [31:0] limit;
   logic [27:0] next_entry;
   logic [31:0] cand;
   logic        cand_ok;
   logic [27:0] cand_cl;
   logic [29:0] offset;
   logic [2:0]  nbytes;
   result_type  elem_res;
   result_type  req_res;
   result_type  one_res;

   // The held item moves on whenever the result buffer has room.
   assign advance    = in_valid_ff && buf_space;
   assign req_tready = !in_valid_ff || buf_space;
   assign pair_valid = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= req_tuser;
         in_start_ff <= req_tdata[31:0];
         in_entry_ff <= req_tdata[63:32];
      end
   end

   // Largest usable cluster for the current format; the unused code has none.
   always_comb begin
      case (csr_in.fat_type)
         FatType12: limit = Limit12;
         FatType16: limit = Limit16;
         FatType32: limit = Limit32;
         default:   limit = '0;
      endcase
   end

   // Entry decode: FAT12 picks a nibble-aligned 12-bit field by cluster parity.
   always_comb begin
      case (csr_in.fat_type)
         FatType12: begin
            if (cur_ff[0]) begin
               next_entry = {16'd0, in_entry_ff[15:4]};
            end else begin
               next_entry = {16'd0, in_entry_ff[11:0]};
            end
         end
         FatType16: next_entry = {12'd0, in_entry_ff[15:0]};
         default:   next_entry = in_entry_ff[27:0];
      endcase
   end

   // Candidate cluster: the start value or the decoded entry.
   assign cand    = (in_op_ff == OpStart) ? in_start_ff : {4'd0, next_entry};
   assign cand_ok = (cand >= MinCluster) && (cand <= limit);
   assign cand_cl = cand[27:0];

   // Byte offset of the entry within the table.
   always_comb begin
      case (csr_in.fat_type)
         FatType12: begin
            offset = 30'({1'b0, cand_cl} + {2'b0, cand_cl[27:1]});
            nbytes = ReadBytesShort;
         end
         FatType16: begin
            offset = {1'b0, cand_cl, 1'b0};
            nbytes = ReadBytesShort;
         end
         default: begin
            offset = {cand_cl, 2'b0};
            nbytes = ReadBytesLong;
         end
      endcase
   end

   // Element and read request for a valid cluster.
   always_comb begin
      elem_res              = '0;
      elem_res.kind         = KindElement;
      elem_res.cluster      = cand_cl;
      req_res               = '0;
      req_res.kind          = KindReadReq;
      req_res.cluster       = cand_cl;
      req_res.read_address  = 31'({1'b0, csr_in.base_address} + {1'b0, offset});
      req_res.read_bytes    = nbytes;
      req_res.last          = 1'b1;
   end

   // Single-result outcomes: bad start, end of chain or stray data.
   always_comb begin
      one_res      = '0;
      one_res.last = 1'b1;
      if (in_op_ff == OpStart) begin
         one_res.kind    = KindBadStart;
         one_res.cluster = cand_cl;
      end else if (walking_ff) begin
         one_res.kind    = KindEndOfChain;
         one_res.cluster = cand_cl;
      end else begin
         one_res.kind    = KindUnexpected;
      end
   end

   // Result pair and the state the item leaves behind.
   always_comb begin
      pair_out   = '0;
      cur_in     = cur_ff;
      walking_in = walking_ff;
      if ((in_op_ff == OpEntry) && !walking_ff) begin
         pair_out.first = one_res;
      end else if (cand_ok) begin
         pair_out.two    = 1'b1;
         pair_out.first  = elem_res;
         pair_out.second = req_res;
         cur_in          = cand_cl;
         walking_in      = 1'b1;
      end else begin
         pair_out.first = one_res;
         walking_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= '0;
         walking_ff <= 1'b0;
      end else if (advance) begin
         cur_ff     <= cur_in;
         walking_ff <= walking_in;
      end
   end

endmodule : fcw_core

`default_nettype wire

// ===== rtl/fcw_rsp_buf.sv =====
// Two-entry result register that plays out one or two results per item.
`default_nettype none

module fcw_rsp_buf (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pair_valid,
   input  wire fcw_pkg::pair_type      pair_in,
   output      logic                   buf_space,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      fcw_pkg::result_type    rsp_head
);
   import fcw_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   result_type slot0_ff;
   result_type slot1_ff;
   logic       take;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign take       = rsp_tvalid && rsp_tready;
   // Room for a new pair once at most the final result is leaving.
   assign buf_space  = (count_ff == 2'd0) || ((count_ff == 2'd1) && take);
   assign rsp_head   = slot0_ff;

   // Occupancy: a load replaces the contents, a take drains one.
   always_comb begin
      count_in = count_ff;
      if (pair_valid) begin
         count_in = pair_in.two ? 2'd2 : 2'd1;
      end else if (take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result slots: load the pair, or shift the second result forward.
   always_ff @(posedge clock) begin
      if (pair_valid) begin
         slot0_ff <= pair_in.first;
         slot1_ff <= pair_in.second;
      end else if (take) begin
         slot0_ff <= slot1_ff;
      end
   end

endmodule : fcw_rsp_buf

`default_nettype wire

// ===== rtl/fat_cluster_chain_walker.sv =====
// Top level of the FAT cluster chain walker.
//
//  Channel | Direction | Payload
//  req_    | in        | tdata: start_cluster[31:0], entry_data[63:32]; tuser: op
//  rsp_    | out       | tdata: cluster, read_address, read_bytes; tuser: kind; tlast
//  csr_    | in        | csr_index (register), csr_data (value)
//
// An item is held in the input register and decoded combinationally into the
// result register, so items flow at one per cycle while each causes one result
// and the output is not stalled; the port carries one result per cycle, so an
// element and a read request hold back the next item until the second leaves.
// Reset is synchronous and clears the walk state and both handshake stages.
// A stalled output holds the input register, which then backs up req_tready.
`default_nettype none

module fat_cluster_chain_walker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // start_cluster [31:0], entry_data [63:32]
   input  wire logic [63:0] req_tdata,
   // op [0]
   input  wire logic        req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // cluster [27:0], read_address [58:28], read_bytes [61:59], zero [63:62]
   output      logic [63:0] rsp_tdata,
   // kind [2:0]
   output      logic [2:0]  rsp_tuser,
   output      logic        rsp_tlast,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import fcw_pkg::*;

   csr_type    csr_cfg;
   logic       buf_space;
   logic       pair_valid;
   pair_type   pair;
   result_type head;

   // Configuration registers.
   fcw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_out   (csr_cfg)
   );

   // Input register and decode.
   fcw_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_in     (csr_cfg),
      .buf_space  (buf_space),
      .pair_valid (pair_valid),
      .pair_out   (pair)
   );

   // Result register.
   fcw_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .pair_valid (pair_valid),
      .pair_in    (pair),
      .buf_space  (buf_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_head   (head)
   );

   // Pack the result transaction.
   assign rsp_tdata = {2'b00, head.read_bytes, head.read_address, head.cluster};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule : fat_cluster_chain_walker

`default_nettype wire
